FILE: hdl/hvfu_pkg.sv
// Shared types, constants and helpers for the HMM Viterbi frame update block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package hvfu_pkg;

  localparam int SCORE_W        = 32;
  localparam int TRANS_W        = 64;
  localparam int NUM_TRANS      = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int MAX_STATES_DEF = 5;
  localparam int TOPO_STATES    = 5;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [TRANS_W-1:0] trans_t;

  localparam score_t LOGPROB_ZERO = -32'sd939524096;
  localparam score_t HIST_NONE    = -32'sd1;
  localparam score_t SCORE_MAX    = 32'sh7FFF_FFFF;
  localparam score_t SCORE_MIN    = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 3'd0,
    CFG_TRANS_A = 3'd1,
    CFG_TRANS_B = 3'd2,
    CFG_TRANS_C = 3'd3,
    CFG_TRANS_D = 3'd4,
    CFG_TRANS_E = 3'd5,
    CFG_TRANS_F = 3'd6,
    CFG_TRANS_G = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    CMD_EVAL  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic {
    MODE_THREE = 1'b0,
    MODE_FIVE  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    PICK_SELF = 2'd0,
    PICK_NEAR = 2'd1,
    PICK_FAR  = 2'd2
  } pick_t;

  // Signed add clamped to the 32-bit range.
  function automatic score_t sat_add(input score_t a, input score_t b);
    logic signed [SCORE_W:0] s;
    s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
    if (s[SCORE_W] != s[SCORE_W-1]) begin
      sat_add = s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end else begin
      sat_add = s[SCORE_W-1:0];
    end
  endfunction

endpackage

FILE: hdl/hvfu_if.sv
// Valid/ready channel interfaces for the input and result beats.
// Depends on hvfu_pkg for the score type.
`timescale 1ns / 1ps

interface hvfu_in_if import hvfu_pkg::*; ;
  logic   valid;
  logic   ready;
  logic   command;
  score_t entry_score;
  score_t entry_history;
  score_t senone_score_0;
  score_t senone_score_1;
  score_t senone_score_2;
  score_t senone_score_3;
  score_t senone_score_4;

  modport source (
    output valid, command, entry_score, entry_history,
           senone_score_0, senone_score_1, senone_score_2, senone_score_3, senone_score_4,
    input  ready
  );
  modport sink (
    input  valid, command, entry_score, entry_history,
           senone_score_0, senone_score_1, senone_score_2, senone_score_3, senone_score_4,
    output ready
  );
endinterface

interface hvfu_out_if import hvfu_pkg::*; ;
  logic   valid;
  logic   ready;
  score_t best_score;
  score_t exit_score;
  score_t exit_history;

  modport source (output valid, best_score, exit_score, exit_history, input ready);
  modport sink (input valid, best_score, exit_score, exit_history, output ready);
endinterface

FILE: hdl/hvfu_lane.sv
// One HMM state: holds its score and history and applies the Viterbi step.
// Depends on hvfu_pkg (score type, saturating add, pick codes).
`timescale 1ns / 1ps

module hvfu_lane import hvfu_pkg::*; #(
  parameter bit NEAR_ADD = 1'b1,  // 0: near candidate taken as is (entry)
  parameter bit FAR_USE  = 1'b1   // 0: no skip arc into this state
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   update,
  input  logic   clear,
  input  score_t self_weight,
  input  score_t near_score,
  input  score_t near_weight,
  input  score_t near_hist,
  input  score_t far_score,
  input  score_t far_weight,
  input  score_t far_hist,
  input  score_t senone,
  output score_t score,
  output score_t hist
);

  score_t c_self, c_near, c_far, c_win, h_win;
  pick_t  win;

  always_comb begin
    c_self = sat_add(score, self_weight);
    c_near = NEAR_ADD ? sat_add(near_score, near_weight) : near_score;
    // Missing skip arc: most negative value never wins a strict compare.
    c_far  = FAR_USE ? sat_add(far_score, far_weight) : SCORE_MIN;
    if (c_self < c_near) begin
      win = (c_near >= c_far) ? PICK_NEAR : PICK_FAR;
    end else begin
      win = (c_self < c_far) ? PICK_FAR : PICK_SELF;
    end
    case (win)
      PICK_NEAR: begin
        c_win = c_near;
        h_win = near_hist;
      end
      PICK_FAR: begin
        c_win = c_far;
        h_win = far_hist;
      end
      default: begin
        c_win = c_self;
        h_win = hist;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      score <= LOGPROB_ZERO;
      hist  <= HIST_NONE;
    end else if (update) begin
      score <= sat_add(c_win, senone);
      hist  <= h_win;
    end
  end

endmodule

FILE: hdl/hvfu_merge.sv
// Merges the lane states into best score and exit score/history.
// Depends on hvfu_pkg.
`timescale 1ns / 1ps

module hvfu_merge import hvfu_pkg::*; #(
  parameter int MAX_STATES = MAX_STATES_DEF
) (
  input  score_t score [MAX_STATES],
  input  score_t hist  [MAX_STATES],
  input  logic   five,
  input  logic   clear,
  input  score_t exit_w_prev,
  input  score_t exit_w_last,
  output score_t best,
  output score_t exit_score,
  output score_t exit_hist
);

  localparam int LAST = MAX_STATES - 1;

  score_t max_s, s_last, s_prev, h_last, h_prev, e_last, e_prev;

  always_comb begin
    max_s = score[0];
    for (int k = 1; k < MAX_STATES; k++) begin
      if ((k < 3 || five) && max_s < score[k]) max_s = score[k];
    end
    s_last = five ? score[LAST]   : score[2];
    h_last = five ? hist[LAST]    : hist[2];
    s_prev = five ? score[LAST-1] : score[1];
    h_prev = five ? hist[LAST-1]  : hist[1];
    e_last = sat_add(s_last, exit_w_last);
    e_prev = sat_add(s_prev, exit_w_prev);
    if (clear) begin
      best       = LOGPROB_ZERO;
      exit_score = LOGPROB_ZERO;
      exit_hist  = HIST_NONE;
    end else begin
      best = max_s;
      if (e_last < e_prev) begin
        exit_score = e_prev;
        exit_hist  = h_prev;
      end else begin
        exit_score = e_last;
        exit_hist  = h_last;
      end
    end
  end

endmodule

FILE: hdl/hmm_viterbi_frame_update.sv
// An accepted beat updates the lane state registers and sets s1_valid; its result
// then enters the output register once that is free. Throughput: one beat per cycle
// unless the sink stalls; each lane's add/compare/add recurrence is combinational.
// Reset (rst, synchronous, active high): five-state mode, all weights zero,
// scores at log-zero, histories -1, pipeline empty.
`timescale 1ns / 1ps

module hmm_viterbi_frame_update import hvfu_pkg::*; #(
  parameter int MAX_STATES = MAX_STATES_DEF   // 3..5 emitting states of storage
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 write_en,
  input  logic [CFG_IDX_W-1:0] write_index,
  input  logic [TRANS_W-1:0]   write_data,
  hvfu_in_if.sink              in_ch,
  hvfu_out_if.source           out_ch
);

  // Configuration registers
  mode_t  mode;
  trans_t trans [NUM_TRANS];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_FIVE;
      for (int i = 0; i < NUM_TRANS; i++) trans[i] <= '0;
    end else if (write_en) begin
      unique case (cfg_idx_t'(write_index))
        CFG_MODE:    mode     <= mode_t'(write_data[0]);
        CFG_TRANS_A: trans[0] <= write_data;
        CFG_TRANS_B: trans[1] <= write_data;
        CFG_TRANS_C: trans[2] <= write_data;
        CFG_TRANS_D: trans[3] <= write_data;
        CFG_TRANS_E: trans[4] <= write_data;
        CFG_TRANS_F: trans[5] <= write_data;
        CFG_TRANS_G: trans[6] <= write_data;
        default: ;
      endcase
    end
  end

  // Five states only when the storage is there for them
  logic five;
  assign five = (mode == MODE_FIVE) && (MAX_STATES >= 5);

  // Arc weights per lane, unpacked from the register halves
  score_t w_self [TOPO_STATES];
  score_t w_near [TOPO_STATES];
  score_t w_far  [TOPO_STATES];
  score_t senone [TOPO_STATES];

  assign w_self[0] = trans[0][31:0];
  assign w_near[0] = '0;              // entry arc carries no weight
  assign w_far[0]  = '0;
  assign w_self[1] = trans[1][63:32];
  assign w_near[1] = trans[0][63:32];
  assign w_far[1]  = '0;
  assign w_self[2] = trans[3][31:0];
  assign w_near[2] = trans[2][31:0];
  assign w_far[2]  = trans[1][31:0];
  assign w_self[3] = trans[4][63:32];
  assign w_near[3] = trans[3][63:32];
  assign w_far[3]  = trans[2][63:32];
  assign w_self[4] = trans[6][31:0];
  assign w_near[4] = trans[5][31:0];
  assign w_far[4]  = trans[4][31:0];

  assign senone[0] = in_ch.senone_score_0;
  assign senone[1] = in_ch.senone_score_1;
  assign senone[2] = in_ch.senone_score_2;
  assign senone[3] = in_ch.senone_score_3;
  assign senone[4] = in_ch.senone_score_4;

  // Handshake: state stage (s1) feeding the output register
  logic s1_valid, s1_clear, out_valid, out_load, in_fire, do_eval, do_clear;

  assign out_load    = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || out_load;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign do_eval     = in_fire && (cmd_t'(in_ch.command) == CMD_EVAL);
  assign do_clear    = in_fire && (cmd_t'(in_ch.command) == CMD_CLEAR);

  // Lanes: one per state, the active ones updated in the same beat from the old scores
  score_t st_score [MAX_STATES];
  score_t st_hist  [MAX_STATES];

  for (genvar k = 0; k < MAX_STATES; k++) begin : g_lane
    score_t near_s, near_h, far_s, far_h;
    logic   lane_en;

    if (k == 0) begin : g_entry
      assign near_s = in_ch.entry_score;
      assign near_h = in_ch.entry_history;
    end else begin : g_prev
      assign near_s = st_score[k-1];
      assign near_h = st_hist[k-1];
    end
    if (k >= 2) begin : g_skip
      assign far_s = st_score[k-2];
      assign far_h = st_hist[k-2];
    end else begin : g_noskip
      assign far_s = LOGPROB_ZERO;
      assign far_h = HIST_NONE;
    end
    // States 3 and 4 skip evaluation in three-state mode (a clear still resets them)
    assign lane_en = do_eval && (k < 3 || five);

    hvfu_lane #(
      .NEAR_ADD (k != 0),
      .FAR_USE  (k >= 2)
    ) u_lane (
      .clk         (clk),
      .rst         (rst),
      .update      (lane_en),
      .clear       (do_clear),
      .self_weight (w_self[k]),
      .near_score  (near_s),
      .near_weight (w_near[k]),
      .near_hist   (near_h),
      .far_score   (far_s),
      .far_weight  (w_far[k]),
      .far_hist    (far_h),
      .senone      (senone[k]),
      .score       (st_score[k]),
      .hist        (st_hist[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_clear <= do_clear;
  end

  // Merge: best over active states, exit from the last two; log-zero after a clear
  score_t m_best, m_exit, m_exit_hist;

  hvfu_merge #(.MAX_STATES(MAX_STATES)) u_merge (
    .score       (st_score),
    .hist        (st_hist),
    .five        (five),
    .clear       (s1_clear),
    .exit_w_prev (trans[5][63:32]),
    .exit_w_last (trans[6][63:32]),
    .best        (m_best),
    .exit_score  (m_exit),
    .exit_hist   (m_exit_hist)
  );

  // Output register; holds its beat while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.best_score   <= m_best;
      out_ch.exit_score   <= m_exit;
      out_ch.exit_history <= m_exit_hist;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

FILE: hdl/hvfu_check.sv
// Port-level checks for hmm_viterbi_frame_update, attached by bind.
// Depends on hvfu_pkg and the top level's ports.
`timescale 1ns / 1ps

module hvfu_check import hvfu_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input score_t best_score,
  input score_t exit_score,
  input score_t exit_history
);

  // A stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(best_score) && $stable(exit_score)
                                && $stable(exit_history))
    else $error("stalled result payload changed");

  // Input only backs up behind a full output register
  a_ready_bp: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // A beat taken while the output is empty leads to a valid result beat
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |-> ##2 out_valid)
    else $error("result missing after accepted beat");

endmodule

bind hmm_viterbi_frame_update hvfu_check u_hvfu_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .best_score   (out_ch.best_score),
  .exit_score   (out_ch.exit_score),
  .exit_history (out_ch.exit_history)
);
